>>> src/zero_one_knapsack_dp_macros.svh
// Assertion macros for the knapsack DP block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ZERO_ONE_KNAPSACK_DP_MACROS_SVH
`define ZERO_ONE_KNAPSACK_DP_MACROS_SVH

// check while out of reset
`define KNAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define KNAP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/knap_pkg.sv
// Shared types and constants for the knapsack DP block.
// No dependencies; imported by zero_one_knapsack_dp and knap_alu.
`default_nettype none
package knap_pkg;

  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 10;
  localparam int BEST_W   = 32;
  localparam int CAP_W    = 10;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 10'd1023;
  localparam logic [BEST_W-1:0] BEST_MAX  = {BEST_W{1'b1}};

  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [BEST_W-1:0]   best_t;
  typedef logic [CAP_W-1:0]    cap_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic fit;          // weight fits at this entry
    logic zero_entry;   // entry 0, always zero
    logic clear_entry;  // last item: write zero behind the walk
  } alu_ctrl_t;

endpackage
`default_nettype wire

>>> src/zero_one_knapsack_dp.sv
// 0/1 knapsack DP top level: sequencer walking a row RAM through one shared update unit.
// Sequence: an accepted word walks the row from entry MAX_CAPACITY down to 0, then drains; ready
// rises after the drain, or after the emit state on a last word, which loads its result unless held.
// Throughput: one row entry per cycle; no new word is accepted until the walk and drain are through.
// Reset: synchronous; a clearing pass zeroes every row entry first.
// Depends on knap_pkg, knap_ram, knap_alu and zero_one_knapsack_dp_macros.svh.
`default_nettype none
`include "zero_one_knapsack_dp_macros.svh"
module zero_one_knapsack_dp #(
  parameter int MAX_CAPACITY = 1023
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // item_value [15:0], item_weight [25:16], zero fill [31:26]
  input  wire logic [knap_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // best_value [31:0]
  output logic      [knap_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [knap_pkg::CAP_W-1:0]      cfg_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready
);
  import knap_pkg::*;

  localparam int DEPTH = MAX_CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = ((AW > WEIGHT_W) ? AW : WEIGHT_W) + 1;
  localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_CAPACITY);
  localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_CAPACITY);

  state_t          state_r, state_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  cap_t            cap_r;
  value_t          value_r;
  weight_t         weight_r;
  logic            last_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]   s1_idx_r;
  alu_ctrl_t       s1_ctrl_r;
  logic            s1_cap_hit_r;
  best_t           cap_val_r;
  logic            out_valid_r, out_valid_nxt;
  best_t           out_data_r;

  logic            accept;
  logic            issue;
  logic            load_out;
  logic [CMP_W-1:0] diff;
  logic [CMP_W-1:0] cap_ext;
  logic [AW-1:0]   cap_idx;
  alu_ctrl_t       issue_ctrl;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  best_t           ram_wdata;
  best_t           rd_old;
  best_t           rd_base;
  best_t           alu_best;
  best_t           alu_wdata;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign diff    = CMP_W'(j_r) - CMP_W'(weight_r);
  assign cap_ext = CMP_W'(cap_r);
  assign cap_idx = (cap_ext > MAX_EXT) ? LAST_IDX : cap_ext[AW-1:0];

  always_comb begin
    issue_ctrl.fit         = !diff[CMP_W-1];
    issue_ctrl.zero_entry  = (j_r == '0);
    issue_ctrl.clear_entry = last_r;
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    issue     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        j_nxt = j_r - 1'b1;
        if (j_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WALK;
          j_nxt     = LAST_IDX;
        end
      end
      ST_WALK: begin
        issue = 1'b1;
        j_nxt = j_r - 1'b1;
        if (j_r == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    s1_valid_nxt  = issue;
    out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = j_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid_r;
      ram_waddr = s1_idx_r;
      ram_wdata = alu_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      j_r         <= LAST_IDX;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r  <= in_tdata[VALUE_W-1:0];
      weight_r <= in_tdata[VALUE_W +: WEIGHT_W];
      last_r   <= in_tlast;
    end
    if (issue) begin
      s1_idx_r     <= j_r;
      s1_ctrl_r    <= issue_ctrl;
      s1_cap_hit_r <= (j_r == cap_idx);
    end
    if (s1_valid_r && s1_cap_hit_r) begin
      cap_val_r <= alu_best;
    end
    if (load_out) begin
      out_data_r <= cap_val_r;
    end
  end

  knap_ram #(
    .WIDTH (BEST_W),
    .DEPTH (DEPTH)
  ) u_row (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (j_r),
    .ra_data (rd_old),
    .rb_addr (diff[AW-1:0]),
    .rb_data (rd_base)
  );

  knap_alu u_alu (
    .old_best   (rd_old),
    .base_best  (rd_base),
    .item_value (value_r),
    .ctrl       (s1_ctrl_r),
    .new_best   (alu_best),
    .wdata      (alu_wdata)
  );

  `KNAP_ASSERT_RST(a_reset_no_out, !rst_n |=> !out_valid_r, "result valid after reset")
  `KNAP_ASSERT(a_idle_no_write, state_r == ST_IDLE |-> !s1_valid_r, "row write pending in idle")
  `KNAP_ASSERT(a_accept_walk, accept |=> state_r == ST_WALK && j_r == LAST_IDX,
    "accepted word did not start a walk")
  `KNAP_ASSERT(a_clear_zero, state_r == ST_CLEAR |-> ram_we && ram_wdata == '0,
    "clearing pass wrote nonzero data")
  `KNAP_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> $past(state_r) == ST_EMIT,
    "result raised outside emit")

endmodule
`default_nettype wire

>>> src/knap_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module knap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule
`default_nettype wire

>>> src/knap_alu.sv
// Shared update unit: saturating add of the item value and max against the entry.
// Depends on knap_pkg.
`default_nettype none
module knap_alu (
  input  wire knap_pkg::best_t     old_best,
  input  wire knap_pkg::best_t     base_best,
  input  wire knap_pkg::value_t    item_value,
  input  wire knap_pkg::alu_ctrl_t ctrl,
  output knap_pkg::best_t          new_best,
  output knap_pkg::best_t          wdata
);
  import knap_pkg::*;

  logic [BEST_W:0] sum;
  best_t           cand;
  logic            take;

  always_comb begin
    sum  = {1'b0, base_best} + {{(BEST_W + 1 - VALUE_W){1'b0}}, item_value};
    cand = sum[BEST_W] ? BEST_MAX : sum[BEST_W-1:0];
    take = ctrl.fit && (cand > old_best);
    if (ctrl.zero_entry) begin
      new_best = '0;
    end else if (take) begin
      new_best = cand;
    end else begin
      new_best = old_best;
    end
    wdata = ctrl.clear_entry ? '0 : new_best;
  end

endmodule
`default_nettype wire
